@@ hw/rtl/mxpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mxpt_pkg
// Shared types, codes and the xorshift32 step for the memory pattern tester.
// ----------------------------------------------------------------------------
package mxpt_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned CountW    = 29;
  localparam int unsigned CountExtW = CountW + 1;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgIndexW = 1;

  localparam logic [ModeW-1:0] ModeRestart = 2'd0;
  localparam logic [ModeW-1:0] ModeWrite   = 2'd1;
  localparam logic [ModeW-1:0] ModeCheck   = 2'd2;

  localparam logic [CfgIndexW-1:0] RegSeed      = 1'b0;
  localparam logic [CfgIndexW-1:0] RegWordCount = 1'b1;

  localparam logic [DataW-1:0]  SeedReset      = 32'd1;
  localparam logic [CountW-1:0] WordCountReset = 29'h1000_0000;

  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  typedef struct packed {
    logic [CountW-1:0] index;
    logic [DataW-1:0]  pattern_word;
    logic              mismatch;
    logic              fail_seen;
    logic              last_word;
  } mxpt_result_t;

  function automatic logic [DataW-1:0] xorshift_next(input logic [DataW-1:0] x);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] c;
    a = x ^ (x << ShiftA);
    b = a ^ (a >> ShiftB);
    c = b ^ (b << ShiftC);
    return c;
  endfunction

endpackage

@@ hw/rtl/mxpt_stream_if.sv @@
// ----------------------------------------------------------------------------
// mxpt stream interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface mxpt_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [mxpt_pkg::ModeW-1:0]   mode;
  logic [mxpt_pkg::DataW-1:0]   read_data;

  modport source (output valid, output mode, output read_data, input ready);
  modport sink   (input valid, input mode, input read_data, output ready);
endinterface

interface mxpt_result_if #(
  parameter int unsigned ADDRESS_BITS = 28
);
  logic                        valid;
  logic                        ready;
  logic [ADDRESS_BITS-1:0]     word_address;
  logic [mxpt_pkg::DataW-1:0]  pattern_word;
  logic                        mismatch;
  logic                        fail_seen;
  logic                        last_word;

  modport source (output valid, output word_address, output pattern_word,
                  output mismatch, output fail_seen, output last_word, input ready);
  modport sink   (input valid, input word_address, input pattern_word,
                  input mismatch, input fail_seen, input last_word, output ready);
endinterface

@@ hw/rtl/mxpt_core.sv @@
// ----------------------------------------------------------------------------
// mxpt_core
// Command register, generator state and result computation.
// ----------------------------------------------------------------------------
module mxpt_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mxpt_pkg::ModeW-1:0]        in_mode,
  input  logic [mxpt_pkg::DataW-1:0]        in_read_data,
  input  logic [mxpt_pkg::DataW-1:0]        seed,
  input  logic [mxpt_pkg::CountExtW-1:0]    count,
  output logic                              res_valid,
  input  logic                              res_ready,
  output mxpt_pkg::mxpt_result_t            res
);

  localparam int unsigned CntW = mxpt_pkg::CountExtW;

  logic                          hold_valid;
  logic [mxpt_pkg::ModeW-1:0]    hold_mode;
  logic [mxpt_pkg::DataW-1:0]    hold_data;

  logic [mxpt_pkg::DataW-1:0]    gen;
  logic [mxpt_pkg::CountW-1:0]   idx;
  logic                          fail;
  logic                          done;

  logic [mxpt_pkg::DataW-1:0]    gen_next;
  logic                          is_step;
  logic                          produces;
  logic                          advance;
  logic                          miss;
  logic                          last;

  always_comb begin
    gen_next = mxpt_pkg::xorshift_next(gen);
    is_step  = (hold_mode == mxpt_pkg::ModeWrite) || (hold_mode == mxpt_pkg::ModeCheck);
    produces = is_step && !done;
    miss     = (hold_mode == mxpt_pkg::ModeCheck) && (hold_data != gen_next);
    last     = (({1'b0, idx} + CntW'(1)) >= count);
    advance  = hold_valid && (!produces || res_ready);
    in_ready = !hold_valid || advance;

    res_valid        = hold_valid && produces;
    res.index        = idx;
    res.pattern_word = gen_next;
    res.mismatch     = miss;
    res.fail_seen    = fail || miss;
    res.last_word    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_mode <= in_mode;
      hold_data <= in_read_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen  <= mxpt_pkg::SeedReset;
      idx  <= '0;
      fail <= 1'b0;
      done <= 1'b0;
    end else if (advance) begin
      if (hold_mode == mxpt_pkg::ModeRestart) begin
        gen  <= seed;
        idx  <= '0;
        fail <= 1'b0;
        done <= 1'b0;
      end else if (produces) begin
        gen  <= gen_next;
        idx  <= idx + mxpt_pkg::CountW'(1);
        fail <= fail || miss;
        done <= last;
      end
    end
  end

endmodule

@@ hw/rtl/mxpt_out_reg.sv @@
// ----------------------------------------------------------------------------
// mxpt_out_reg
// Result register that drives the result channel.
// ----------------------------------------------------------------------------
module mxpt_out_reg #(
  parameter int unsigned ADDRESS_BITS = 28
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mxpt_pkg::mxpt_result_t  in_res,
  mxpt_result_if.source           out
);

  logic                    valid_q;
  mxpt_pkg::mxpt_result_t  res_q;

  assign in_ready = !valid_q || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
    if (in_valid && in_ready) begin
      res_q <= in_res;
    end
  end

  assign out.valid        = valid_q;
  assign out.word_address = ADDRESS_BITS'(res_q.index);
  assign out.pattern_word = res_q.pattern_word;
  assign out.mismatch     = res_q.mismatch;
  assign out.fail_seen    = res_q.fail_seen;
  assign out.last_word    = res_q.last_word;

endmodule

@@ hw/rtl/memory_xorshift_pattern_test_unit.sv @@
// ----------------------------------------------------------------------------
// memory_xorshift_pattern_test_unit
// Xorshift32 pattern writer and checker for memory self-test.
// ----------------------------------------------------------------------------
// Takes one command per clock and gives at most one result per clock while
// the result side does not stall. A command goes into a command register,
// the generator step, compare and last-word test run from there, and the
// result lands in an output register that drives the result channel.
// The result register takes a new result in the same cycle the waiting one
// transfers; a stall on the result side holds the command side once the
// command register also holds an item with a result waiting. The xorshift
// step and the 30-bit index compare set the cycle. Restart, an unused mode
// and any step after the pass is done give no result. Word count zero
// counts as one word; counts above 2**ADDRESS_BITS saturate there.
// ----------------------------------------------------------------------------
module memory_xorshift_pattern_test_unit #(
  parameter int unsigned ADDRESS_BITS = 28
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [mxpt_pkg::CfgIndexW-1:0]     wr_index,
  input  logic [mxpt_pkg::DataW-1:0]         wr_data,
  mxpt_cmd_if.sink                           cmd,
  mxpt_result_if.source                      result
);

  localparam int unsigned CntW       = mxpt_pkg::CountExtW;
  localparam int unsigned LimitShift =
      (ADDRESS_BITS < mxpt_pkg::CountW) ? ADDRESS_BITS : mxpt_pkg::CountW;
  localparam logic [CntW-1:0] CountLimit = CntW'(1) << LimitShift;
  localparam logic [CntW-1:0] CountResetEff =
      ({1'b0, mxpt_pkg::WordCountReset} > CountLimit) ? CountLimit
                                                      : {1'b0, mxpt_pkg::WordCountReset};

  logic [mxpt_pkg::DataW-1:0]   seed;
  logic [CntW-1:0]              count;
  logic [mxpt_pkg::CountW-1:0]  wc;
  logic [CntW-1:0]              count_wr;

  logic                         res_valid;
  logic                         res_ready;
  mxpt_pkg::mxpt_result_t       res;

  // Store the word count already clamped to the addressable range, zero as one.
  always_comb begin
    wc = wr_data[mxpt_pkg::CountW-1:0];
    if (wc == '0) begin
      count_wr = CntW'(1);
    end else if ({1'b0, wc} > CountLimit) begin
      count_wr = CountLimit;
    end else begin
      count_wr = {1'b0, wc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed  <= mxpt_pkg::SeedReset;
      count <= CountResetEff;
    end else if (wr_en) begin
      case (wr_index)
        mxpt_pkg::RegSeed:      seed  <= wr_data;
        mxpt_pkg::RegWordCount: count <= count_wr;
        default: ;
      endcase
    end
  end

  mxpt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cmd.valid),
    .in_ready     (cmd.ready),
    .in_mode      (cmd.mode),
    .in_read_data (cmd.read_data),
    .seed         (seed),
    .count        (count),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  mxpt_out_reg #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_res   (res),
    .out      (result)
  );

  a_miss_sets_fail: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.mismatch |-> res.fail_seen)
    else $error("mismatch without sticky fail flag");

  a_res_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid &&
    $stable({result.word_address, result.pattern_word, result.mismatch,
             result.fail_seen, result.last_word}))
    else $error("result transfer changed while stalled");

endmodule
